// ----- sv/lidar_point_deskew_transform_macros.svh -----
// Assertion helpers used by the checker.
`ifndef LIDAR_POINT_DESKEW_TRANSFORM_MACROS_SVH
`define LIDAR_POINT_DESKEW_TRANSFORM_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define LDT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("lidar deskew check failed");

// Next-cycle implication, clocked on clk, off during reset.
`define LDT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error("lidar deskew check failed");

`endif

// ----- sv/ldt_pkg.sv -----
package ldt_pkg;

  localparam int TRIG_FRAC    = 28;
  localparam int TRIG_GAIN    = 163008219;
  localparam int ATAN_ENTRIES = 30;
  localparam int LANES        = 6;
  localparam int COORD_W      = 40;
  localparam int ANG_W        = 34;
  localparam int SPLIT        = 20;

  typedef logic signed [31:0]        trig_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [ANG_W-1:0]   zang_t;

  typedef enum logic [2:0] {
    REG_ROT_X,
    REG_ROT_Y,
    REG_ROT_Z,
    REG_SHIFT_X,
    REG_SHIFT_Y,
    REG_SHIFT_Z
  } cfg_reg_e;

  // Arctangent of 2^-i, 2^32 = 2 pi.
  localparam logic signed [31:0] ATAN [ATAN_ENTRIES] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
    32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772, 32'sd166886,
    32'sd83443, 32'sd41722, 32'sd20861, 32'sd10430, 32'sd5215, 32'sd2608,
    32'sd1304, 32'sd652, 32'sd326, 32'sd163, 32'sd81, 32'sd41, 32'sd20,
    32'sd10, 32'sd5, 32'sd3, 32'sd1
  };

  // Lanes 0..2: scaled x, y, z angles. Lanes 3..5: full x, y, z angles.
  // Per rotation step: trig lane, first and second coordinate.
  localparam int ROT_LANE [6] = '{2, 0, 1, 4, 3, 5};
  localparam int ROT_U    [6] = '{0, 1, 2, 0, 2, 1};
  localparam int ROT_V    [6] = '{1, 2, 0, 2, 1, 0};

  typedef struct packed {
    logic [LANES-1:0]  neg;
    trig_t [LANES-1:0] x;
    trig_t [LANES-1:0] y;
    zang_t [LANES-1:0] z;
  } cord_t;

  typedef struct packed {
    logic               valid;
    logic               to_end;
    logic [15:0]        tag;
    logic [15:0]        t;
    coord_t [2:0]       pos;
  } side_t;

  typedef struct packed {
    logic               valid;
    logic               to_end;
    logic [15:0]        tag;
    logic [15:0]        t;
    trig_t [LANES-1:0]  cs;
    trig_t [LANES-1:0]  sn;
    coord_t [2:0]       pos;
  } tok_t;

endpackage

// ----- sv/ldt_cordic_cell.sv -----
module ldt_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  ldt_pkg::cord_t cin,
  output ldt_pkg::cord_t cout
);
  import ldt_pkg::*;

  cord_t nxt;

  // One micro-rotation on every lane.
  always_comb begin
    trig_t xj;
    trig_t yj;
    zang_t zj;
    nxt = cin;
    for (int j = 0; j < LANES; j++) begin
      xj = cin.x[j];
      yj = cin.y[j];
      zj = cin.z[j];
      if (!zj[ANG_W-1]) begin
        nxt.x[j] = xj - (yj >>> IDX);
        nxt.y[j] = yj + (xj >>> IDX);
        nxt.z[j] = zj - ANG_W'(ATAN[IDX]);
      end else begin
        nxt.x[j] = xj + (yj >>> IDX);
        nxt.y[j] = yj - (xj >>> IDX);
        nxt.z[j] = zj + ANG_W'(ATAN[IDX]);
      end
    end
  end

  always_ff @(posedge clk) begin
    cout <= nxt;
  end

endmodule

// ----- sv/ldt_rot_cell.sv -----
module ldt_rot_cell (
  input  logic           clk,
  input  ldt_pkg::trig_t c,
  input  ldt_pkg::trig_t s,
  input  ldt_pkg::coord_t u,
  input  ldt_pkg::coord_t v,
  output ldt_pkg::coord_t o1,
  output ldt_pkg::coord_t o2
);
  import ldt_pkg::*;

  localparam int HI_W  = COORD_W - SPLIT;
  localparam int PH_W  = 32 + HI_W;
  localparam int PL_W  = 32 + SPLIT + 1;
  localparam int ACC_W = 32 + COORD_W + 2;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (TRIG_FRAC - 1);

  logic signed [HI_W-1:0]  uh, vh;
  logic signed [SPLIT:0]   ul, vl;
  logic signed [PH_W-1:0]  cuh, svh, cvh, suh;
  logic signed [PL_W-1:0]  cul, svl, cvl, sul;
  logic signed [ACC_W-1:0] acc1, acc2;

  assign uh = u[COORD_W-1:SPLIT];
  assign vh = v[COORD_W-1:SPLIT];
  assign ul = {1'b0, u[SPLIT-1:0]};
  assign vl = {1'b0, v[SPLIT-1:0]};

  // Split each coordinate so every product stays within 32 x 21 bits.
  always_ff @(posedge clk) begin
    cuh <= c * uh;
    cul <= c * ul;
    svh <= s * vh;
    svl <= s * vl;
    cvh <= c * vh;
    cvl <= c * vl;
    suh <= s * uh;
    sul <= s * ul;
  end

  assign acc1 = (ACC_W'(cuh) <<< SPLIT) + ACC_W'(cul)
              + (ACC_W'(svh) <<< SPLIT) + ACC_W'(svl) + HALF;
  assign acc2 = (ACC_W'(cvh) <<< SPLIT) + ACC_W'(cvl)
              - (ACC_W'(suh) <<< SPLIT) - ACC_W'(sul) + HALF;

  always_ff @(posedge clk) begin
    o1 <= COORD_W'(acc1 >>> TRIG_FRAC);
    o2 <= COORD_W'(acc2 >>> TRIG_FRAC);
  end

endmodule

// ----- sv/lidar_point_deskew_transform.sv -----
// Channel   | Handshake              | Payload
// ----------+------------------------+-----------------------------------------------
// point in  | start, busy            | req_type, point_x/y/z, ring_tag, sweep_time
// result    | done (one-cycle beat)  | out_x/y/z, out_ring_tag, out_sweep_time, clipped
// config    | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// One point is taken every cycle; busy stays low and cfg_ready stays high.
// Each result passes through one input stage, one CORDIC cell per step, one
// trig stage, six two-stage rotation cells and one saturating output stage.
// rst is synchronous and clears all valid bits and the six motion registers.
// The result side cannot stall; done marks each beat for exactly one cycle.
module lidar_point_deskew_transform #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               req_type,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic [15:0]        ring_tag,
  input  logic [15:0]        sweep_time,
  output logic               done,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [15:0]        out_ring_tag,
  output logic [15:0]        out_sweep_time,
  output logic               clipped,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import ldt_pkg::*;

  localparam zang_t QUARTER = ANG_W'(64'sd1073741824);
  localparam zang_t HALF_PI = ANG_W'(64'sd2147483648);
  localparam logic signed [48:0] T_HALF = 49'sd32768;
  localparam logic signed [COORD_W:0] SAT_MAX = (COORD_W+1)'(64'sd2147483647);
  localparam logic signed [COORD_W:0] SAT_MIN = -(COORD_W+1)'(64'sd2147483648);

  // Motion registers.
  logic signed [15:0] rot [3];
  logic signed [31:0] shift [3];

  // Input stage.
  logic               p0_valid;
  logic               p0_to_end;
  logic [15:0]        p0_tag;
  logic [15:0]        p0_t;
  logic signed [31:0] p0_pt  [3];
  logic signed [31:0] p0_ang [3];
  logic signed [48:0] p0_sht [3];

  logic signed [32:0] ang_prod [3];
  logic signed [48:0] sht_prod [3];
  logic signed [16:0] t_s;
  logic               accept;

  cord_t cord [CORDIC_STEPS+1];
  side_t side [CORDIC_STEPS];
  side_t side_next;
  tok_t  tok0;
  tok_t  tok0_next;
  tok_t  tk [7];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign t_s       = {1'b0, sweep_time};

  // Config writes; unknown indexes drop.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < 3; j++) begin
        rot[j]   <= '0;
        shift[j] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_e'(cfg_index))
        REG_ROT_X:   rot[0]   <= cfg_data[15:0];
        REG_ROT_Y:   rot[1]   <= cfg_data[15:0];
        REG_ROT_Z:   rot[2]   <= cfg_data[15:0];
        REG_SHIFT_X: shift[0] <= cfg_data;
        REG_SHIFT_Y: shift[1] <= cfg_data;
        REG_SHIFT_Z: shift[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Scale angles and shifts by the sweep time.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ang_prod[j] = rot[j] * t_s;
      sht_prod[j] = shift[j] * t_s;
    end
  end

  always_ff @(posedge clk) begin
    p0_to_end <= req_type;
    p0_tag    <= ring_tag;
    p0_t      <= sweep_time;
    p0_pt[0]  <= point_x;
    p0_pt[1]  <= point_y;
    p0_pt[2]  <= point_z;
    for (int j = 0; j < 3; j++) begin
      p0_ang[j] <= ang_prod[j][31:0];
      p0_sht[j] <= sht_prod[j];
    end
    if (rst) begin
      p0_valid <= 1'b0;
    end else begin
      p0_valid <= accept;
    end
  end

  // Fold angles into [-pi/2, pi/2] and seed the CORDIC chain. Full-sweep
  // angles come straight from the motion registers, sign extended.
  always_comb begin
    zang_t z;
    for (int j = 0; j < LANES; j++) begin
      if (j < 3) begin
        z = ANG_W'(p0_ang[j]);
      end else begin
        z = ANG_W'($signed({rot[j-3], 16'b0}));
      end
      cord[0].x[j]   = TRIG_GAIN;
      cord[0].y[j]   = '0;
      cord[0].neg[j] = 1'b0;
      if (z > QUARTER) begin
        z = z - HALF_PI;
        cord[0].neg[j] = 1'b1;
      end else if (z < -QUARTER) begin
        z = z + HALF_PI;
        cord[0].neg[j] = 1'b1;
      end
      cord[0].z[j] = z;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    ldt_cordic_cell #(.IDX(k)) u_cell (
      .clk  (clk),
      .cin  (cord[k]),
      .cout (cord[k+1])
    );
  end

  // Point side line: remove the scaled translation, then ride along.
  always_comb begin
    side_next.valid  = p0_valid;
    side_next.to_end = p0_to_end;
    side_next.tag    = p0_tag;
    side_next.t      = p0_t;
    for (int j = 0; j < 3; j++) begin
      side_next.pos[j] = COORD_W'(p0_pt[j]) - COORD_W'((p0_sht[j] + T_HALF) >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        side[k].valid <= 1'b0;
      end
    end else begin
      side[0] <= side_next;
      for (int k = 1; k < CORDIC_STEPS; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  // Undo the fold and join trig values with the point.
  always_comb begin
    tok0_next.valid  = side[CORDIC_STEPS-1].valid;
    tok0_next.to_end = side[CORDIC_STEPS-1].to_end;
    tok0_next.tag    = side[CORDIC_STEPS-1].tag;
    tok0_next.t      = side[CORDIC_STEPS-1].t;
    tok0_next.pos    = side[CORDIC_STEPS-1].pos;
    for (int j = 0; j < LANES; j++) begin
      tok0_next.cs[j] = cord[CORDIC_STEPS].neg[j] ? -cord[CORDIC_STEPS].x[j]
                                                  : cord[CORDIC_STEPS].x[j];
      tok0_next.sn[j] = cord[CORDIC_STEPS].neg[j] ? -cord[CORDIC_STEPS].y[j]
                                                  : cord[CORDIC_STEPS].y[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok0.valid <= 1'b0;
    end else begin
      tok0 <= tok0_next;
    end
  end

  assign tk[0] = tok0;

  // Six planar rotations: z, x, y scaled back to sweep start, then y, x, z
  // forward to sweep end when requested.
  for (genvar k = 0; k < 6; k++) begin : g_rot
    localparam bit ALWAYS = (k < 3);
    tok_t   tm;
    tok_t   td;
    tok_t   tk_c;
    coord_t o1;
    coord_t o2;

    ldt_rot_cell u_cell (
      .clk (clk),
      .c   (tk[k].cs[ROT_LANE[k]]),
      .s   (tk[k].sn[ROT_LANE[k]]),
      .u   (tk[k].pos[ROT_U[k]]),
      .v   (tk[k].pos[ROT_V[k]]),
      .o1  (o1),
      .o2  (o2)
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        tm.valid <= 1'b0;
        td.valid <= 1'b0;
      end else begin
        tm <= tk[k];
        td <= tm;
      end
    end

    always_comb begin
      tk_c = td;
      if (ALWAYS || td.to_end) begin
        tk_c.pos[ROT_U[k]] = o1;
        tk_c.pos[ROT_V[k]] = o2;
      end
    end

    assign tk[k+1] = tk_c;
  end

  // Add the full translation in end mode, saturate and flag.
  logic signed [COORD_W:0] fin [3];
  logic signed [31:0]      sat [3];
  logic                    clip_any;

  always_comb begin
    clip_any = 1'b0;
    for (int j = 0; j < 3; j++) begin
      fin[j] = (COORD_W+1)'(tk[6].pos[j]);
      if (tk[6].to_end) begin
        fin[j] = fin[j] + (COORD_W+1)'(shift[j]);
      end
      if (fin[j] > SAT_MAX) begin
        sat[j]   = 32'sh7fffffff;
        clip_any = 1'b1;
      end else if (fin[j] < SAT_MIN) begin
        sat[j]   = 32'sh80000000;
        clip_any = 1'b1;
      end else begin
        sat[j] = fin[j][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_x          <= sat[0];
    out_y          <= sat[1];
    out_z          <= sat[2];
    out_ring_tag   <= tk[6].tag;
    out_sweep_time <= tk[6].to_end ? 16'd0 : tk[6].t;
    clipped        <= clip_any;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tk[6].valid;
    end
  end

endmodule

// ----- sv/ldt_checker.sv -----
`include "lidar_point_deskew_transform_macros.svh"

module ldt_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [31:0] out_x,
  input logic signed [31:0] out_y,
  input logic signed [31:0] out_z,
  input logic               clipped,
  input logic               cfg_ready
);

  localparam int LAT = CORDIC_STEPS + 15;

  // Every accepted point leaves as a done beat.
  `LDT_ASSERT_IMPL(a_beat_out, start && !busy, ##LAT done)
  // No result beat without a matching accept.
  `LDT_ASSERT_IMPL(a_beat_src, done, $past(start && !busy, LAT))
  // The flag is only raised on a limit value.
  `LDT_ASSERT_IMPL(a_clip, done && clipped,
    out_x == 32'sh7fffffff || out_x == 32'sh80000000 ||
    out_y == 32'sh7fffffff || out_y == 32'sh80000000 ||
    out_z == 32'sh7fffffff || out_z == 32'sh80000000)
  // Streams without stalls on either channel.
  `LDT_ASSERT_NEXT(a_nostall, 1'b1, !busy && cfg_ready)

endmodule

bind lidar_point_deskew_transform ldt_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_chk (.*);
